/* hdl/ebjq_pkg.sv */
// ebjq_pkg: shared types, codes and sizes of the event bridge job queue
// used by ebjq_front, ebjq_back and event_bridge_job_queue_unit
// depends on nothing
package ebjq_pkg;

   // job ring
   localparam int QUEUE_DEPTH = 8;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int OP_W       = 3;
   localparam int ID_W       = 8;
   localparam int ADDR_W     = 16;
   localparam int TIME_W     = 48;
   localparam int AGE_W      = 32;
   localparam int CNT_W      = 32;
   localparam int CIDX_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // internal queues between the parts and at the result side
   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 2;

   localparam logic [ADDR_W-1:0] UNICAST_LIMIT = 16'h8000;

   // statistics counters
   localparam int NUM_COUNTERS           = 15;
   localparam int C_SER_NOOP             = 0;
   localparam int C_SER_INVALID          = 1;
   localparam int C_SER_VALID            = 2;
   localparam int C_NOT_READY            = 3;
   localparam int C_FULL_TO_MESH         = 4;
   localparam int C_FULL_TO_SERIAL       = 5;
   localparam int C_MESH_INVALID         = 6;
   localparam int C_MESH_VALID           = 7;
   localparam int C_MESH_SELF            = 8;
   localparam int C_ACCEPTED_TO_MESH     = 9;
   localparam int C_ACCEPTED_TO_SERIAL   = 10;
   localparam int C_FAILED_TO_MESH       = 11;
   localparam int C_FAILED_TO_SERIAL     = 12;
   localparam int C_EXPIRED_TO_MESH      = 13;
   localparam int C_EXPIRED_TO_SERIAL    = 14;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ADDR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE_MS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_ID    = 2'd2;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd5000;

   typedef enum logic [OP_W-1:0] {
      OP_SERIAL   = 3'd0,
      OP_MESH     = 3'd1,
      OP_TAKE     = 3'd2,
      OP_COMPLETE = 3'd3,
      OP_READ     = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOOP      = 3'd1,
      ST_INVALID   = 3'd2,
      ST_NOT_READY = 3'd3,
      ST_FULL      = 3'd4,
      ST_SELF      = 3'd5,
      ST_EMPTY     = 3'd6,
      ST_EXPIRED   = 3'd7
   } status_type;

   // what the back part does with a classified item
   typedef enum logic [1:0] {
      ACT_REPORT = 2'd0,
      ACT_PUSH   = 2'd1,
      ACT_TAKE   = 2'd2,
      ACT_READ   = 2'd3
   } act_type;

   typedef struct packed {
      logic [ADDR_W-1:0] node_addr;
      logic [AGE_W-1:0]  max_age_ms;
      logic [ID_W-1:0]   none_id;
   } cfg_type;

   typedef struct packed {
      act_type                 action;
      status_type              status;
      logic [NUM_COUNTERS-1:0] inc;
      logic [ID_W-1:0]         id;
      logic [ADDR_W-1:0]       src;
      logic                    dir;
      logic [TIME_W-1:0]       now;
      logic                    ready;
      logic [CIDX_W-1:0]       cidx;
   } cmd_type;

   typedef struct packed {
      logic              dir;
      logic [ADDR_W-1:0] src;
      logic [ID_W-1:0]   id;
   } tag_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   job_id;
      logic [ADDR_W-1:0] job_source;
      logic              job_direction;
      logic [TIME_W-1:0] job_received_ms;
      logic [CNT_W-1:0]  counter_value;
   } rsp_type;

endpackage

/* hdl/event_bridge_job_queue_unit.sv */
// event_bridge_job_queue_unit: top level of the event bridge job queue
// holds the configuration registers; instantiates ebjq_front and ebjq_back
// and uses ebjq_pkg
//
// usage
// - items enter through a queue-like port: an item is taken at a clock edge
//   with push high and full low; every item gives exactly one result
// - results leave through a queue-like port: the oldest result sits on the
//   rsp_ ports while empty is low and is taken at an edge with pop high
// - csr port: a write happens at every edge with csr_write_enable high;
//   index 0 node address, 1 max_age_ms, 2 none_id; other indexes are ignored
// - a taken item passes the command queue register, then the result queue
//   register, before its result is on the rsp_ ports
// - throughput: one item per cycle while the result queue has room or is
//   popped, set by the single execute step of the back part (one ring slot
//   access and the item's counter updates per cycle)
// - when pop stays low the two-entry result queue fills, then the back part
//   holds and the two-entry command queue fills, then full goes high
// - reset (synchronous) empties all queues and the job ring, clears the
//   statistics counters and loads the register reset values
module event_bridge_job_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   // input item channel
   input  logic                             push,
   output logic                             full,
   input  logic [ebjq_pkg::OP_W-1:0]        req_opcode,
   input  logic [ebjq_pkg::ID_W-1:0]        req_event_id,
   input  logic                             req_id_ok,
   input  logic [ebjq_pkg::ADDR_W-1:0]      req_source_address,
   input  logic [ebjq_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                             req_mesh_up,
   input  logic                             req_direction,
   input  logic                             req_accepted,
   input  logic [ebjq_pkg::CIDX_W-1:0]      req_counter_index,
   // result channel
   output logic                             empty,
   input  logic                             pop,
   output logic [2:0]                       rsp_status,
   output logic [ebjq_pkg::ID_W-1:0]        rsp_job_id,
   output logic [ebjq_pkg::ADDR_W-1:0]      rsp_job_source,
   output logic                             rsp_job_direction,
   output logic [ebjq_pkg::TIME_W-1:0]      rsp_job_received_ms,
   output logic [ebjq_pkg::CNT_W-1:0]       rsp_counter_value,
   // configuration writes
   input  logic                             csr_write_enable,
   input  logic [ebjq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ebjq_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ebjq_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   // register writes; the user must write only while the block is idle, the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NODE_ADDR:  cfg_in.node_addr  = csr_write_data[ADDR_W-1:0];
            CSR_MAX_AGE_MS: cfg_in.max_age_ms = csr_write_data[AGE_W-1:0];
            CSR_NONE_ID:    cfg_in.none_id    = csr_write_data[ID_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_addr  <= '0;
         cfg_ff.max_age_ms <= MAX_AGE_RESET;
         cfg_ff.none_id    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   ebjq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_opcode         (req_opcode),
      .req_event_id       (req_event_id),
      .req_id_ok          (req_id_ok),
      .req_source_address (req_source_address),
      .req_now_ms         (req_now_ms),
      .req_mesh_up        (req_mesh_up),
      .req_direction      (req_direction),
      .req_accepted       (req_accepted),
      .req_counter_index  (req_counter_index),
      .cfg                (cfg_ff),
      .cmd_valid          (cmd_valid),
      .cmd_take           (cmd_take),
      .cmd                (cmd)
   );

   // back: job ring, counters and result queue
   ebjq_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd_valid           (cmd_valid),
      .cmd_take            (cmd_take),
      .cmd                 (cmd),
      .empty               (empty),
      .pop                 (pop),
      .rsp_status          (rsp_status),
      .rsp_job_id          (rsp_job_id),
      .rsp_job_source      (rsp_job_source),
      .rsp_job_direction   (rsp_job_direction),
      .rsp_job_received_ms (rsp_job_received_ms),
      .rsp_counter_value   (rsp_counter_value)
   );

endmodule

/* hdl/ebjq_front.sv */
// ebjq_front: accepts items, classifies them against the configuration
// and keeps them in a short command queue for the back part; uses ebjq_pkg
module ebjq_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [ebjq_pkg::OP_W-1:0]    req_opcode,
   input  logic [ebjq_pkg::ID_W-1:0]    req_event_id,
   input  logic                         req_id_ok,
   input  logic [ebjq_pkg::ADDR_W-1:0]  req_source_address,
   input  logic [ebjq_pkg::TIME_W-1:0]  req_now_ms,
   input  logic                         req_mesh_up,
   input  logic                         req_direction,
   input  logic                         req_accepted,
   input  logic [ebjq_pkg::CIDX_W-1:0]  req_counter_index,
   input  ebjq_pkg::cfg_type            cfg,
   output logic                         cmd_valid,
   input  logic                         cmd_take,
   output ebjq_pkg::cmd_type            cmd
);
   import ebjq_pkg::*;

   cmd_type    cmdq_ff [CMDQ_DEPTH];
   logic       cmdq_head_ff, cmdq_head_in;
   logic [1:0] cmdq_count_ff, cmdq_count_in;
   logic       cmdq_tail;
   logic       accept;
   cmd_type    new_cmd;

   assign full      = (cmdq_count_ff == 2'(CMDQ_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cmdq_count_ff != 2'd0);
   assign cmd       = cmdq_ff[cmdq_head_ff];
   assign cmdq_tail = cmdq_head_ff ^ cmdq_count_ff[0];

   // classification
   always_comb begin
      new_cmd        = '0;
      new_cmd.action = ACT_REPORT;
      new_cmd.status = ST_INVALID;
      new_cmd.id     = req_event_id;
      new_cmd.now    = req_now_ms;
      new_cmd.ready  = req_mesh_up;
      new_cmd.cidx   = req_counter_index;
      unique case (opcode_type'(req_opcode))
         OP_SERIAL: begin
            if (req_event_id == cfg.none_id) begin
               new_cmd.status          = ST_NOOP;
               new_cmd.inc[C_SER_NOOP] = 1'b1;
            end else if (!req_id_ok) begin
               new_cmd.inc[C_SER_INVALID] = 1'b1;
            end else begin
               new_cmd.inc[C_SER_VALID] = 1'b1;
               if (!req_mesh_up) begin
                  new_cmd.status           = ST_NOT_READY;
                  new_cmd.inc[C_NOT_READY] = 1'b1;
               end else begin
                  new_cmd.action = ACT_PUSH;
                  new_cmd.dir    = 1'b0;
               end
            end
         end
         OP_MESH: begin
            if (!req_id_ok || req_source_address == '0
                || req_source_address >= UNICAST_LIMIT) begin
               new_cmd.inc[C_MESH_INVALID] = 1'b1;
            end else begin
               new_cmd.inc[C_MESH_VALID] = 1'b1;
               if (req_source_address == cfg.node_addr) begin
                  new_cmd.status           = ST_SELF;
                  new_cmd.inc[C_MESH_SELF] = 1'b1;
               end else begin
                  new_cmd.action = ACT_PUSH;
                  new_cmd.src    = req_source_address;
                  new_cmd.dir    = 1'b1;
               end
            end
         end
         OP_TAKE: begin
            new_cmd.action = ACT_TAKE;
         end
         OP_COMPLETE: begin
            new_cmd.status = ST_OK;
            case ({req_accepted, req_direction})
               2'b10:   new_cmd.inc[C_ACCEPTED_TO_MESH]   = 1'b1;
               2'b11:   new_cmd.inc[C_ACCEPTED_TO_SERIAL] = 1'b1;
               2'b00:   new_cmd.inc[C_FAILED_TO_MESH]     = 1'b1;
               default: new_cmd.inc[C_FAILED_TO_SERIAL]   = 1'b1;
            endcase
         end
         OP_READ: begin
            if (req_counter_index < CIDX_W'(NUM_COUNTERS)) begin
               new_cmd.action = ACT_READ;
               new_cmd.status = ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      cmdq_head_in  = cmdq_head_ff ^ cmd_take;
      cmdq_count_in = cmdq_count_ff + 2'(accept) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmdq_head_ff  <= 1'b0;
         cmdq_count_ff <= 2'd0;
      end else begin
         cmdq_head_ff  <= cmdq_head_in;
         cmdq_count_ff <= cmdq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmdq_ff[cmdq_tail] <= new_cmd;
      end
   end

endmodule

/* hdl/ebjq_back.sv */
// ebjq_back: carries out classified items on the job ring and the
// statistics counters, and queues the results; uses ebjq_pkg
module ebjq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ebjq_pkg::cfg_type            cfg,
   input  logic                         cmd_valid,
   output logic                         cmd_take,
   input  ebjq_pkg::cmd_type            cmd,
   output logic                         empty,
   input  logic                         pop,
   output logic [2:0]                   rsp_status,
   output logic [ebjq_pkg::ID_W-1:0]    rsp_job_id,
   output logic [ebjq_pkg::ADDR_W-1:0]  rsp_job_source,
   output logic                         rsp_job_direction,
   output logic [ebjq_pkg::TIME_W-1:0]  rsp_job_received_ms,
   output logic [ebjq_pkg::CNT_W-1:0]   rsp_counter_value
);
   import ebjq_pkg::*;

   localparam int SUM_W = QIDX_W + 1;

   // job ring, no reset: a slot is read only after it was written
   logic [TIME_W-1:0] job_time_ff [QUEUE_DEPTH];
   tag_type           job_tag_ff  [QUEUE_DEPTH];
   logic [QIDX_W-1:0] ring_head_ff, ring_head_in;
   logic [QCNT_W-1:0] ring_count_ff, ring_count_in;
   logic [SUM_W-1:0]  tail_sum;
   logic [QIDX_W-1:0] ring_tail;
   logic [QIDX_W-1:0] head_next;

   logic [CNT_W-1:0]  counter_ff [NUM_COUNTERS];

   rsp_type           rspq_ff [RSPQ_DEPTH];
   logic              rspq_head_ff, rspq_head_in;
   logic [1:0]        rspq_count_ff, rspq_count_in;
   logic              rspq_tail;
   logic              rsp_fire;

   logic                    exec;
   logic                    do_push, do_take;
   logic [NUM_COUNTERS-1:0] inc;
   rsp_type                 res;
   tag_type                 head_tag;
   logic [TIME_W-1:0]       head_time;
   logic [TIME_W:0]         age;
   logic                    expired;
   tag_type                 job_tag_in;

   assign empty    = (rspq_count_ff == 2'd0);
   assign rsp_fire = pop && !empty;
   assign exec     = cmd_valid && ((rspq_count_ff != 2'(RSPQ_DEPTH)) || rsp_fire);
   assign cmd_take = exec;

   assign tail_sum  = SUM_W'(ring_head_ff) + SUM_W'(ring_count_ff);
   assign ring_tail = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? QIDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
   assign head_next = (ring_head_ff == QIDX_W'(QUEUE_DEPTH - 1))
                      ? '0 : ring_head_ff + QIDX_W'(1);

   assign head_tag  = job_tag_ff[ring_head_ff];
   assign head_time = job_time_ff[ring_head_ff];
   // future timestamp shows as a borrow
   assign age       = {1'b0, cmd.now} - {1'b0, head_time};
   assign expired   = age[TIME_W] || (age[TIME_W-1:0] >= TIME_W'(cfg.max_age_ms));

   assign job_tag_in = '{dir: cmd.dir, src: cmd.src, id: cmd.id};

   always_comb begin
      res         = '0;
      res.status  = cmd.status;
      inc         = cmd.inc;
      do_push     = 1'b0;
      do_take     = 1'b0;
      unique case (cmd.action)
         ACT_REPORT: ;
         ACT_PUSH: begin
            if (ring_count_ff == QCNT_W'(QUEUE_DEPTH)) begin
               res.status = ST_FULL;
               if (cmd.dir) begin
                  inc[C_FULL_TO_SERIAL] = 1'b1;
               end else begin
                  inc[C_FULL_TO_MESH] = 1'b1;
               end
            end else begin
               res.status = ST_OK;
               do_push    = 1'b1;
            end
         end
         ACT_TAKE: begin
            if (ring_count_ff == '0) begin
               res.status = ST_EMPTY;
            end else begin
               do_take             = 1'b1;
               res.job_id          = head_tag.id;
               res.job_source      = head_tag.src;
               res.job_direction   = head_tag.dir;
               res.job_received_ms = head_time;
               if (expired) begin
                  res.status = ST_EXPIRED;
                  if (head_tag.dir) begin
                     inc[C_EXPIRED_TO_SERIAL] = 1'b1;
                  end else begin
                     inc[C_EXPIRED_TO_MESH] = 1'b1;
                  end
               end else if (!head_tag.dir && !cmd.ready) begin
                  res.status       = ST_NOT_READY;
                  inc[C_NOT_READY] = 1'b1;
               end else begin
                  res.status = ST_OK;
               end
            end
         end
         ACT_READ: begin
            res.counter_value = counter_ff[cmd.cidx];
         end
         default: ;
      endcase
   end

   always_comb begin
      ring_head_in  = ring_head_ff;
      ring_count_in = ring_count_ff;
      if (exec && do_push) begin
         ring_count_in = ring_count_ff + QCNT_W'(1);
      end
      if (exec && do_take) begin
         ring_head_in  = head_next;
         ring_count_in = ring_count_ff - QCNT_W'(1);
      end
      rspq_head_in  = rspq_head_ff ^ rsp_fire;
      rspq_count_in = rspq_count_ff + 2'(exec) - 2'(rsp_fire);
   end

   assign rspq_tail = rspq_head_ff ^ rspq_count_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_head_ff  <= '0;
         ring_count_ff <= '0;
         rspq_head_ff  <= 1'b0;
         rspq_count_ff <= 2'd0;
      end else begin
         ring_head_ff  <= ring_head_in;
         ring_count_ff <= ring_count_in;
         rspq_head_ff  <= rspq_head_in;
         rspq_count_ff <= rspq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         if (reset) begin
            counter_ff[i] <= '0;
         end else if (exec && inc[i]) begin
            counter_ff[i] <= counter_ff[i] + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec && do_push) begin
         job_time_ff[ring_tail] <= cmd.now;
         job_tag_ff[ring_tail]  <= job_tag_in;
      end
      if (exec) begin
         rspq_ff[rspq_tail] <= res;
      end
   end

   assign rsp_status          = rspq_ff[rspq_head_ff].status;
   assign rsp_job_id          = rspq_ff[rspq_head_ff].job_id;
   assign rsp_job_source      = rspq_ff[rspq_head_ff].job_source;
   assign rsp_job_direction   = rspq_ff[rspq_head_ff].job_direction;
   assign rsp_job_received_ms = rspq_ff[rspq_head_ff].job_received_ms;
   assign rsp_counter_value   = rspq_ff[rspq_head_ff].counter_value;

endmodule

/* tb/sv/tb_event_bridge_job_queue_unit.sv */
// tb_event_bridge_job_queue_unit: self-checking bench for the event bridge job queue
// drives items and csr writes, predicts every result and checks it field by field
// depends on ebjq_pkg and event_bridge_job_queue_unit
module tb_event_bridge_job_queue_unit;
   import ebjq_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int MAX_PAUSE     = 19;

   // opcodes and counter index the block does not define
   localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
   localparam logic [CIDX_W-1:0] CIDX_SPARE     = 4'd15;
   localparam logic [ADDR_W-1:0] ADDR_NONE      = '0;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ID_W-1:0]   event_id;
      logic              id_ok;
      logic [ADDR_W-1:0] source;
      logic [TIME_W-1:0] now_ms;
      logic              mesh_up;
      logic              direction;
      logic              accepted;
      logic [CIDX_W-1:0] counter_index;
   } bridge_item_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   job_id;
      logic [ADDR_W-1:0] job_source;
      logic              job_direction;
      logic [TIME_W-1:0] job_received_ms;
      logic [CNT_W-1:0]  counter_value;
   } bridge_result_type;

   // clock, reset and every block input start at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  push = 1'b0;
   logic                  full;
   logic [OP_W-1:0]       req_opcode = '0;
   logic [ID_W-1:0]       req_event_id = '0;
   logic                  req_id_ok = 1'b0;
   logic [ADDR_W-1:0]     req_source_address = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  req_mesh_up = 1'b0;
   logic                  req_direction = 1'b0;
   logic                  req_accepted = 1'b0;
   logic [CIDX_W-1:0]     req_counter_index = '0;

   logic                  empty;
   logic                  pop = 1'b0;
   logic [2:0]            rsp_status;
   logic [ID_W-1:0]       rsp_job_id;
   logic [ADDR_W-1:0]     rsp_job_source;
   logic                  rsp_job_direction;
   logic [TIME_W-1:0]     rsp_job_received_ms;
   logic [CNT_W-1:0]      rsp_counter_value;

   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   event_bridge_job_queue_unit uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_opcode          (req_opcode),
      .req_event_id        (req_event_id),
      .req_id_ok           (req_id_ok),
      .req_source_address  (req_source_address),
      .req_now_ms          (req_now_ms),
      .req_mesh_up         (req_mesh_up),
      .req_direction       (req_direction),
      .req_accepted        (req_accepted),
      .req_counter_index   (req_counter_index),
      .empty               (empty),
      .pop                 (pop),
      .rsp_status          (rsp_status),
      .rsp_job_id          (rsp_job_id),
      .rsp_job_source      (rsp_job_source),
      .rsp_job_direction   (rsp_job_direction),
      .rsp_job_received_ms (rsp_job_received_ms),
      .rsp_counter_value   (rsp_counter_value),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow of the block: settings, job ring and statistics
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] cfg_own     = '0;
   logic [AGE_W-1:0]  cfg_max_age = MAX_AGE_RESET;
   logic [ID_W-1:0]   cfg_none_id = '0;

   logic [TIME_W-1:0] ring_time [QUEUE_DEPTH];
   tag_type           ring_tag  [QUEUE_DEPTH];
   int                ring_head  = 0;
   int                ring_count = 0;
   logic [CNT_W-1:0]  tally [NUM_COUNTERS] = '{default: '0};

   function automatic void bump(input int idx);
      tally[idx] = tally[idx] + 1'b1;
   endfunction

   // store a job at the tail, or count it as dropped on a full ring
   function automatic status_type enqueue_job(input logic [TIME_W-1:0] stamp,
                                              input logic [ID_W-1:0] id,
                                              input logic [ADDR_W-1:0] src,
                                              input logic dir);
      int slot;
      if (ring_count >= QUEUE_DEPTH) begin
         bump(C_FULL_TO_MESH + dir);
         return ST_FULL;
      end
      slot = (ring_head + ring_count) % QUEUE_DEPTH;
      ring_time[slot] = stamp;
      ring_tag[slot]  = '{dir: dir, src: src, id: id};
      ring_count++;
      return ST_OK;
   endfunction

   // what the block answers to one item, updating the shadow state
   function automatic bridge_result_type bridge_predict(input bridge_item_type it);
      bridge_result_type r;
      logic [TIME_W-1:0] stamp;
      tag_type tg;
      r = '0;
      r.status = ST_INVALID;
      case (it.opcode)
         OP_SERIAL: begin
            if (it.event_id == cfg_none_id) begin
               bump(C_SER_NOOP);
               r.status = ST_NOOP;
            end else if (!it.id_ok) begin
               bump(C_SER_INVALID);
            end else begin
               bump(C_SER_VALID);
               if (!it.mesh_up) begin
                  bump(C_NOT_READY);
                  r.status = ST_NOT_READY;
               end else begin
                  r.status = enqueue_job(it.now_ms, it.event_id, ADDR_NONE, 1'b0);
               end
            end
         end
         OP_MESH: begin
            if (!it.id_ok || it.source == ADDR_NONE || it.source >= UNICAST_LIMIT) begin
               bump(C_MESH_INVALID);
            end else begin
               bump(C_MESH_VALID);
               if (it.source == cfg_own) begin
                  bump(C_MESH_SELF);
                  r.status = ST_SELF;
               end else begin
                  r.status = enqueue_job(it.now_ms, it.event_id, it.source, 1'b1);
               end
            end
         end
         OP_TAKE: begin
            if (ring_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               stamp = ring_time[ring_head];
               tg    = ring_tag[ring_head];
               ring_head  = (ring_head + 1) % QUEUE_DEPTH;
               ring_count--;
               r.job_id          = tg.id;
               r.job_source      = tg.src;
               r.job_direction   = tg.dir;
               r.job_received_ms = stamp;
               // a stamp from the future counts as expired too
               if (it.now_ms < stamp || (it.now_ms - stamp) >= cfg_max_age) begin
                  bump(C_EXPIRED_TO_MESH + tg.dir);
                  r.status = ST_EXPIRED;
               end else if (!tg.dir && !it.mesh_up) begin
                  bump(C_NOT_READY);
                  r.status = ST_NOT_READY;
               end else begin
                  r.status = ST_OK;
               end
            end
         end
         OP_COMPLETE: begin
            bump((it.accepted ? C_ACCEPTED_TO_MESH : C_FAILED_TO_MESH) + it.direction);
            r.status = ST_OK;
         end
         OP_READ: begin
            if (it.counter_index < NUM_COUNTERS) begin
               r.counter_value = tally[it.counter_index];
               r.status = ST_OK;
            end
         end
         default: ;  // spare opcodes leave everything alone
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus shaping
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0] sim_ms = '0;
   int                take_weight = 30;
   logic              sender_calm = 1'b0;
   logic              receiver_calm = 1'b0;

   // per-item pause; now and then a stretch with no pauses at all
   function automatic int sender_pause();
      if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
      return sender_calm ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   function automatic int receiver_pause();
      if ($urandom_range(0, 31) == 0) receiver_calm = !receiver_calm;
      return receiver_calm ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   function automatic bridge_item_type shaped(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic ok,
                                              input logic [ADDR_W-1:0] src,
                                              input logic [TIME_W-1:0] now,
                                              input logic ready);
      bridge_item_type it;
      it.opcode        = op;
      it.event_id      = id;
      it.id_ok         = ok;
      it.source        = src;
      it.now_ms        = now;
      it.mesh_up       = ready;
      it.direction     = $urandom_range(0, 1);
      it.accepted      = $urandom_range(0, 1);
      it.counter_index = $urandom_range(0, NUM_COUNTERS - 1);
      return it;
   endfunction

   // mostly well-formed events on a slowly advancing clock, with some noise
   function automatic bridge_item_type draw_item();
      bridge_item_type it;
      logic [63:0] wide;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)                    it.opcode = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
      else if (roll < 6)               it.opcode = OP_READ;
      else if (roll < 10)              it.opcode = OP_COMPLETE;
      else if (roll < 10 + take_weight) it.opcode = OP_TAKE;
      else if ($urandom_range(0, 1))   it.opcode = OP_SERIAL;
      else                             it.opcode = OP_MESH;

      it.event_id   = ($urandom_range(0, 6) == 0) ? cfg_none_id : $urandom_range(0, 255);
      it.id_ok      = ($urandom_range(0, 9) != 0);
      it.mesh_up    = ($urandom_range(0, 7) != 0);
      it.direction  = $urandom_range(0, 1);
      it.accepted   = $urandom_range(0, 1);
      it.counter_index = ($urandom_range(0, 9) == 0) ? CIDX_SPARE
                                                     : $urandom_range(0, NUM_COUNTERS - 1);
      case ($urandom_range(0, 9))
         0:       it.source = cfg_own;
         1:       it.source = ADDR_NONE;
         2:       it.source = $urandom_range(UNICAST_LIMIT, 16'hFFFF);
         default: it.source = $urandom_range(1, UNICAST_LIMIT - 1);
      endcase

      // time jumps rarely, otherwise creeps forward; a few stamps are wild
      wide = {$urandom, $urandom};
      roll = $urandom_range(0, 49);
      if (roll == 0)
         sim_ms = wide[TIME_W-1:0];
      else if ($urandom_range(0, 1))
         sim_ms = sim_ms + $urandom_range(1, 3000);
      it.now_ms = (roll >= 1 && roll <= 3) ? ~wide[TIME_W-1:0] : sim_ms;
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   bridge_result_type awaited_results[$];
   int                mismatch_count = 0;
   int                results_seen   = 0;

   task automatic flag_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] seen);
      $display("mismatch in %s on result %0d: expected %0h, got %0h",
               field, results_seen, want, seen);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // input side: pending items feed the driver, one item per handshake
   // ---------------------------------------------------------------------
   bridge_item_type pending_items[$];
   bridge_item_type next_item;
   bridge_item_type seen_item;
   int              items_queued = 0;
   int              items_taken  = 0;
   logic            took = 1'b0;
   int              send_wait = 0;

   task automatic schedule_item(input bridge_item_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // an item is taken at this edge: predict its result from what the block saw
   always @(posedge clock) begin
      took <= !reset && push && !full;
      if (!reset && push && !full) begin
         seen_item = '{opcode: req_opcode, event_id: req_event_id, id_ok: req_id_ok,
                       source: req_source_address, now_ms: req_now_ms,
                       mesh_up: req_mesh_up, direction: req_direction,
                       accepted: req_accepted, counter_index: req_counter_index};
         awaited_results.push_back(bridge_predict(seen_item));
         items_taken++;
      end
   end

   // drive at the falling edge; hold an item until it has been taken
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (push && !took) begin
         // still waiting for the block to take it
      end else if (send_wait > 0) begin
         push <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (pending_items.size() != 0) begin
         next_item = pending_items.pop_front();
         req_opcode         <= next_item.opcode;
         req_event_id       <= next_item.event_id;
         req_id_ok          <= next_item.id_ok;
         req_source_address <= next_item.source;
         req_now_ms         <= next_item.now_ms;
         req_mesh_up        <= next_item.mesh_up;
         req_direction      <= next_item.direction;
         req_accepted       <= next_item.accepted;
         req_counter_index  <= next_item.counter_index;
         push <= 1'b1;
         send_wait <= sender_pause();
      end else begin
         push <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // result side: compare each popped item with the oldest prediction
   // ---------------------------------------------------------------------
   bridge_result_type want;
   logic              popped = 1'b0;
   int                pop_wait = 0;

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         popped <= 1'b1;
         results_seen++;
         if (awaited_results.size() == 0) begin
            flag_mismatch("unrequested item status", '0, rsp_status);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", want.status, rsp_status);
            if (rsp_job_id !== want.job_id)
               flag_mismatch("job_id", want.job_id, rsp_job_id);
            if (rsp_job_source !== want.job_source)
               flag_mismatch("job_source", want.job_source, rsp_job_source);
            if (rsp_job_direction !== want.job_direction)
               flag_mismatch("job_direction", want.job_direction, rsp_job_direction);
            if (rsp_job_received_ms !== want.job_received_ms)
               flag_mismatch("job_received_ms", want.job_received_ms, rsp_job_received_ms);
            if (rsp_counter_value !== want.counter_value)
               flag_mismatch("counter_value", want.counter_value, rsp_counter_value);
         end
      end else begin
         popped <= 1'b0;
      end
   end

   // pop stays up until an item leaves, then a random stall
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop && !popped) begin
         // waiting for a result to show up
      end else if (pop_wait > 0) begin
         pop <= 1'b0;
         pop_wait <= pop_wait - 1;
      end else begin
         pop <= 1'b1;
         pop_wait <= receiver_pause();
      end
   end

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, awaited_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequencing: csr writes only while the block is drained
   // ---------------------------------------------------------------------
   task automatic load_settings(input logic [ADDR_W-1:0] own,
                                input logic [AGE_W-1:0] max_age,
                                input logic [ID_W-1:0] none_code);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NODE_ADDR;
      csr_write_data   <= CSR_DATA_W'(own);
      @(negedge clock);
      csr_index        <= CSR_MAX_AGE_MS;
      csr_write_data   <= CSR_DATA_W'(max_age);
      @(negedge clock);
      csr_index        <= CSR_NONE_ID;
      csr_write_data   <= CSR_DATA_W'(none_code);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_own     = own;
      cfg_max_age = max_age;
      cfg_none_id = none_code;
   endtask

   // wait until every scheduled item was taken and answered, then settle
   task automatic drain();
      do @(negedge clock);
      while (items_taken != items_queued || awaited_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      bridge_item_type it;
      int phase;
      int k;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part with reset settings: own 0, max age 5000, none id 0
      schedule_item(shaped(OP_TAKE, 8'h00, 1'b1, 16'h0001, '0, 1'b1));        // empty ring
      schedule_item(shaped(OP_SERIAL, 8'h00, 1'b1, 16'h0000, 48'd10, 1'b1));  // none id
      schedule_item(shaped(OP_SERIAL, 8'hFF, 1'b0, 16'h0000, 48'd10, 1'b1));  // bad id
      schedule_item(shaped(OP_SERIAL, 8'hFF, 1'b1, 16'hFFFF, 48'd10, 1'b0));  // mesh down
      schedule_item(shaped(OP_SERIAL, 8'hAA, 1'b1, 16'h0000, '1, 1'b1));      // stamp at top
      schedule_item(shaped(OP_MESH, 8'h11, 1'b0, 16'h0005, 48'd20, 1'b1));    // not decoded
      schedule_item(shaped(OP_MESH, 8'h22, 1'b1, ADDR_NONE, 48'd20, 1'b0));   // source zero
      schedule_item(shaped(OP_MESH, 8'h33, 1'b1, UNICAST_LIMIT, 48'd20, 1'b1));
      schedule_item(shaped(OP_MESH, 8'h55, 1'b1, UNICAST_LIMIT - 1, 48'd1000, 1'b0));
      schedule_item(shaped(OP_MESH, 8'h00, 1'b1, 16'h0001, '0, 1'b1));
      // fill the ring, then overflow it from both directions
      for (k = 1; k <= 5; k++)
         schedule_item(shaped(OP_SERIAL, ID_W'(k), 1'b1, 16'h0000, 48'd2000, 1'b1));
      schedule_item(shaped(OP_SERIAL, 8'h06, 1'b1, 16'h0000, 48'd2000, 1'b1));
      schedule_item(shaped(OP_MESH, 8'h07, 1'b1, 16'h0002, 48'd2000, 1'b1));
      // future stamp, age one below the limit, age at the limit, mesh down
      schedule_item(shaped(OP_TAKE, 8'h00, 1'b1, 16'h0000, 48'd1000, 1'b1));
      schedule_item(shaped(OP_TAKE, 8'h00, 1'b1, 16'h0000, 48'd5999, 1'b0));
      schedule_item(shaped(OP_TAKE, 8'h00, 1'b1, 16'h0000, 48'd5000, 1'b1));
      schedule_item(shaped(OP_TAKE, 8'h00, 1'b1, 16'h0000, 48'd2000, 1'b0));
      it = shaped(OP_COMPLETE, 8'h00, 1'b1, 16'h0000, '0, 1'b1);
      it.accepted  = 1'b1;
      it.direction = 1'b0;
      schedule_item(it);
      it.accepted  = 1'b0;
      it.direction = 1'b1;
      schedule_item(it);
      it = shaped(OP_READ, 8'h00, 1'b1, 16'h0000, '0, 1'b1);
      it.counter_index = CIDX_SPARE;
      schedule_item(it);
      schedule_item(shaped(OP_SPARE_LAST, 8'hFF, 1'b1, 16'hFFFF, '1, 1'b1));
      drain();

      // random phases, each under its own settings; extremes come first
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_settings(UNICAST_LIMIT - 1, 32'd1, 8'hFF);
            1: load_settings(16'h0001, '1, 8'h00);
            2: load_settings(16'hFFFF, '0, $urandom_range(0, 255));  // everything expires
            default:
               load_settings(($urandom_range(0, 3) != 0) ? $urandom_range(1, UNICAST_LIMIT - 1)
                                                        : $urandom_range(0, 16'hFFFF),
                             ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20000) : $urandom,
                             $urandom_range(0, 255));
         endcase
         take_weight = $urandom_range(15, 50);
         repeat (PHASE_ITEMS) schedule_item(draw_item());
         drain();
      end

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* event_bridge_job_queue_unit.f */
hdl/ebjq_pkg.sv
hdl/ebjq_front.sv
hdl/ebjq_back.sv
hdl/event_bridge_job_queue_unit.sv
tb/sv/tb_event_bridge_job_queue_unit.sv
